[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the project.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/rpc_pkg.sv]
// ---------------------------------------------------------------------------
// rpc_pkg
// Widths, limits and controller/datapath interface types.
// ---------------------------------------------------------------------------
package rpc_pkg;

	localparam int VALUE_W     = 30;
	localparam int MAX_DIGITS  = 32;
	localparam int DIGIT_LIMIT = (MAX_DIGITS < VALUE_W) ? MAX_DIGITS : VALUE_W;
	localparam int IDX_W       = $clog2(MAX_DIGITS);
	localparam int CNT_W       = $clog2(DIGIT_LIMIT + 1);
	localparam int STEP_W      = $clog2(VALUE_W);
	localparam int COUNT_OUT_W = 5;
	localparam int S_TDATA_W   = 64;
	localparam int M_TDATA_W   = 40;

	typedef struct packed {
		logic load;
		logic div_start;
		logic div_store;
		logic cmp_init;
		logic rd;
		logic cmp_step;
		logic emit_init;
		logic emit_dec;
		logic out_load;
	} rpc_cmd_t;

	typedef struct packed {
		logic rem_zero;
		logic cnt_full;
		logic div_done;
		logic lo_lt_hi;
		logic digits_eq;
		logic hi_zero;
		logic out_free;
	} rpc_sts_t;

endpackage

[rtl/rpc_div.sv]
// ---------------------------------------------------------------------------
// rpc_div
// Restoring divider that forms one quotient bit per cycle.
// ---------------------------------------------------------------------------
module rpc_div
	import rpc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [VALUE_W-1:0] dividend,
	input  logic [VALUE_W-1:0] divisor,
	output logic               done,
	output logic [VALUE_W-1:0] quotient,
	output logic [VALUE_W-1:0] remainder
);

	logic               busy_q;
	logic               done_q;
	logic [STEP_W-1:0]  step_q;
	logic [VALUE_W-1:0] r_q;
	logic [VALUE_W-1:0] q_q;
	logic [VALUE_W-1:0] d_q;
	logic [VALUE_W:0]   r_shift;
	logic [VALUE_W:0]   r_diff;
	logic               take;

	assign r_shift = {r_q, q_q[VALUE_W-1]};
	assign r_diff  = r_shift - {1'b0, d_q};
	assign take    = (r_shift >= {1'b0, d_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(VALUE_W - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
			q_q <= dividend;
			d_q <= divisor;
		end else if (busy_q) begin
			r_q <= take ? r_diff[VALUE_W-1:0] : r_shift[VALUE_W-1:0];
			q_q <= {q_q[VALUE_W-2:0], take};
		end
	end

	assign done      = done_q;
	assign quotient  = q_q;
	assign remainder = r_q;

endmodule

[rtl/rpc_dp.sv]
// ---------------------------------------------------------------------------
// rpc_dp
// Datapath: digit conversion, digit memory, compare and output register.
// ---------------------------------------------------------------------------
module rpc_dp
	import rpc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  rpc_cmd_t               cmd,
	output rpc_sts_t               sts,
	input  logic [VALUE_W-1:0]     number,
	input  logic [VALUE_W-1:0]     radix,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [VALUE_W-1:0]     digit,
	output logic                   is_palindrome,
	output logic [COUNT_OUT_W-1:0] digit_count,
	output logic                   last
);

	logic [VALUE_W-1:0]     mem_q [MAX_DIGITS];
	logic [VALUE_W-1:0]     rem_q;
	logic [VALUE_W-1:0]     base_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [IDX_W-1:0]       lo_q;
	logic [IDX_W-1:0]       hi_q;
	logic                   match_q;
	logic [VALUE_W-1:0]     rd_a_q;
	logic [VALUE_W-1:0]     rd_b_q;
	logic                   out_valid_q;
	logic [VALUE_W-1:0]     digit_q;
	logic                   pal_q;
	logic [COUNT_OUT_W-1:0] count_q;
	logic                   last_q;
	logic                   div_done;
	logic [VALUE_W-1:0]     quotient;
	logic [VALUE_W-1:0]     remainder;
	logic                   num_zero;
	logic                   wr_en;
	logic [IDX_W-1:0]       wr_addr;
	logic [VALUE_W-1:0]     wr_data;
	logic [IDX_W-1:0]       cnt_m1;

	rpc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (rem_q),
		.divisor   (base_q),
		.done      (div_done),
		.quotient  (quotient),
		.remainder (remainder)
	);

	assign num_zero = (number == '0);
	assign wr_en    = cmd.div_store || (cmd.load && num_zero);
	assign wr_addr  = cmd.load ? '0 : IDX_W'(cnt_q);
	assign wr_data  = cmd.load ? '0 : remainder;
	assign cnt_m1   = IDX_W'(cnt_q - 1'b1);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (cmd.rd) begin
			rd_a_q <= mem_q[lo_q];
			rd_b_q <= mem_q[hi_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q   <= '0;
			base_q  <= VALUE_W'(2);
			cnt_q   <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			match_q <= 1'b1;
		end else begin
			if (cmd.load) begin
				rem_q  <= number;
				base_q <= (radix < VALUE_W'(2)) ? VALUE_W'(2) : radix;
				cnt_q  <= num_zero ? CNT_W'(1) : '0;
			end
			if (cmd.div_store) begin
				rem_q <= quotient;
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.cmp_init) begin
				lo_q    <= '0;
				hi_q    <= cnt_m1;
				match_q <= 1'b1;
			end
			if (cmd.cmp_step) begin
				if (rd_a_q != rd_b_q) begin
					match_q <= 1'b0;
				end
				lo_q <= lo_q + 1'b1;
			end
			if (cmd.emit_init) begin
				hi_q <= cnt_m1;
			end else if (cmd.cmp_step || cmd.emit_dec) begin
				hi_q <= hi_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			digit_q <= rd_b_q;
			pal_q   <= match_q;
			count_q <= COUNT_OUT_W'(cnt_q);
			last_q  <= (hi_q == '0);
		end
	end

	always_comb begin
		sts.rem_zero  = (rem_q == '0);
		sts.cnt_full  = (cnt_q == CNT_W'(DIGIT_LIMIT));
		sts.div_done  = div_done;
		sts.lo_lt_hi  = (lo_q < hi_q);
		sts.digits_eq = (rd_a_q == rd_b_q);
		sts.hi_zero   = (hi_q == '0);
		sts.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid     = out_valid_q;
	assign digit         = digit_q;
	assign is_palindrome = pal_q;
	assign digit_count   = count_q;
	assign last          = last_q;

endmodule

[rtl/rpc_ctrl.sv]
// ---------------------------------------------------------------------------
// rpc_ctrl
// Controller that sequences conversion, compare and emit passes.
// ---------------------------------------------------------------------------
module rpc_ctrl
	import rpc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  rpc_sts_t sts,
	output rpc_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_DIV_WAIT,
		ST_CMP_RD,
		ST_CMP_CHK,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CONV;
				end
			end
			ST_CONV: begin
				if (sts.rem_zero || sts.cnt_full) begin
					cmd.cmp_init = 1'b1;
					state_d      = ST_CMP_RD;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV_WAIT;
				end
			end
			ST_DIV_WAIT: begin
				if (sts.div_done) begin
					cmd.div_store = 1'b1;
					state_d       = ST_CONV;
				end
			end
			ST_CMP_RD: begin
				if (sts.lo_lt_hi) begin
					cmd.rd  = 1'b1;
					state_d = ST_CMP_CHK;
				end else begin
					cmd.emit_init = 1'b1;
					state_d       = ST_EMIT_RD;
				end
			end
			ST_CMP_CHK: begin
				cmd.cmp_step = 1'b1;
				state_d      = ST_CMP_RD;
				if (!sts.digits_eq) begin
					cmd.emit_init = 1'b1;
					state_d       = ST_EMIT_RD;
				end
			end
			ST_EMIT_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_EMIT_LD;
			end
			ST_EMIT_LD: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					if (sts.hi_zero) begin
						state_d = ST_IDLE;
					end else begin
						cmd.emit_dec = 1'b1;
						state_d      = ST_EMIT_RD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/radix_palindrome_check.sv]
// ---------------------------------------------------------------------------
// radix_palindrome_check
// Converts a number to digits in a given base and tests the digit sequence
// for a palindrome, then streams the digits most significant first.
// ---------------------------------------------------------------------------
// Channel   Direction  Word
// s_axis    in         number, radix
// m_axis    out        digit, is_palindrome, digit_count; tlast on last digit
//
// One word is taken at a time. Each digit is formed in the bit-serial
// divider (one quotient bit per cycle), then digit pairs are compared
// from both ends, and then each digit is read and emitted.
// The digit memory has no reset; counters and the output valid clear at reset.
// A stalled output holds the emit pass; a new word is taken once the last
// digit sits in the output register.
// ---------------------------------------------------------------------------
module radix_palindrome_check
	import rpc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// number [29:0], radix [59:30], zero [63:60]
	input  logic [S_TDATA_W-1:0] s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// digit [29:0], is_palindrome [30], digit_count [35:31], zero [39:36]
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic                 m_tlast
);

	rpc_cmd_t               cmd;
	rpc_sts_t               sts;
	logic [VALUE_W-1:0]     digit;
	logic                   is_palindrome;
	logic [COUNT_OUT_W-1:0] digit_count;

	rpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rpc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.number        (s_tdata[VALUE_W-1:0]),
		.radix         (s_tdata[2*VALUE_W-1:VALUE_W]),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.digit         (digit),
		.is_palindrome (is_palindrome),
		.digit_count   (digit_count),
		.last          (m_tlast)
	);

	assign m_tdata = {{(M_TDATA_W - VALUE_W - 1 - COUNT_OUT_W){1'b0}},
		digit_count, is_palindrome, digit};

endmodule

[rtl/rpc_checker.sv]
// ---------------------------------------------------------------------------
// rpc_checker
// Port-level checks of the stream behavior, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rpc_checker
	import rpc_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic                 m_tlast
);

	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`ASSERT_NEXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready,
		$stable(m_tdata) && $stable(m_tlast))
	`ASSERT_NEXT(a_one_word, clk, arst_n, s_tvalid && s_tready, !s_tready)
	`ASSERT_SAME(a_single_last, clk, arst_n,
		m_tvalid && (m_tdata[35:31] == 5'd1), m_tlast)

endmodule

bind radix_palindrome_check rpc_checker u_rpc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

[tb/sv/testbench.sv]
// ---------------------------------------------------------------------------
// Radix palindrome check testbench
// Sends number and radix words to the block and predicts the digit words it
// must return, most significant digit first, with the palindrome verdict,
// the digit count and tlast. Directed corner words come first, then
// generated palindromes, spoiled palindromes and free random words, with
// random idle gaps on the input side and random stalls on the output side.
// ---------------------------------------------------------------------------
module testbench;
	import rpc_pkg::*;

	localparam longint unsigned VALUE_MAX = (64'd1 << VALUE_W) - 1;
	localparam int WATCHDOG_LIMIT = 6000;
	localparam int DRAIN_CYCLES = 1200;

	typedef struct packed {
		logic [VALUE_W-1:0]     digit;
		logic                   pal;
		logic [COUNT_OUT_W-1:0] count;
		logic                   last;
	} digit_word_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tlast;

	digit_word_t pending_digits[$];
	int          mismatches = 0;
	int          words_sent = 0;
	int          idle_cycles = 0;
	bit          feed_quiet = 1'b0;

	radix_palindrome_check dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void predict_digits(input logic [VALUE_W-1:0] number,
			input logic [VALUE_W-1:0] radix);
		logic [VALUE_W-1:0] rest;
		logic [VALUE_W-1:0] base;
		logic [VALUE_W-1:0] digs[MAX_DIGITS];
		int                 cnt;
		logic               pal;
		digit_word_t        w;
		base = (radix < 2) ? VALUE_W'(2) : radix;
		rest = number;
		cnt = 0;
		if (rest == 0) begin
			digs[0] = '0;
			cnt = 1;
		end
		while (rest != 0 && cnt < DIGIT_LIMIT) begin
			digs[cnt] = rest % base;
			rest = rest / base;
			cnt++;
		end
		pal = 1'b1;
		for (int i = 0; i < cnt / 2; i++)
			if (digs[i] != digs[cnt - 1 - i])
				pal = 1'b0;
		for (int k = cnt - 1; k >= 0; k--) begin
			w.digit = digs[k];
			w.pal = pal;
			w.count = COUNT_OUT_W'(cnt);
			w.last = (k == 0);
			pending_digits.push_back(w);
		end
	endfunction

	// Builds a number whose digits in the chosen base form a palindrome,
	// optionally with one digit of the low half changed.
	function automatic logic [VALUE_W-1:0] shaped_number(input bit spoil,
			output logic [VALUE_W-1:0] base);
		longint unsigned acc;
		int unsigned     digs[MAX_DIGITS];
		int              n;
		int              k;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: base = VALUE_W'($urandom_range(2, 16));
			6, 7, 8: base = VALUE_W'($urandom_range(17, 1000));
			default: base = VALUE_W'($urandom_range(1001, 1000000000));
		endcase
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, DIGIT_LIMIT) : $urandom_range(1, 10);
		n++;
		do begin
			n--;
			for (int i = 0; i < n; i++)
				digs[i] = $urandom_range(0, base - 1);
			digs[n - 1] = $urandom_range(1, base - 1);
			for (int i = 0; i < n / 2; i++)
				digs[i] = digs[n - 1 - i];
			if (spoil && n > 1) begin
				k = $urandom_range(0, n / 2 - 1);
				digs[k] = (digs[k] + $urandom_range(1, base - 1)) % base;
			end
			acc = 0;
			for (int i = n - 1; i >= 0 && acc <= VALUE_MAX; i--)
				acc = acc * base + digs[i];
		end while (acc > VALUE_MAX);
		return VALUE_W'(acc);
	endfunction

	task automatic send_word(input logic [VALUE_W-1:0] number,
			input logic [VALUE_W-1:0] radix);
		int gap;
		if (words_sent % 24 == 0)
			feed_quiet = ($urandom_range(0, 3) == 0);
		gap = feed_quiet ? 0 : $urandom_range(0, 19);
		words_sent++;
		repeat (gap) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {{(S_TDATA_W - 2 * VALUE_W){1'b0}}, radix, number};
		do
			@(posedge clk);
		while (!s_tready);
		predict_digits(number, radix);
		@(negedge clk);
	endtask

	task automatic test_directed();
		send_word(0, 10);
		send_word(0, 0);
		send_word(5, 0);
		send_word(6, 1);
		send_word(1, 2);
		send_word(30'h3FFFFFFF, 2);
		send_word(30'h20000000, 2);
		send_word(30'h3FFFFFFF, 30'h3FFFFFFF);
		send_word(30'h3FFFFFFE, 30'h3FFFFFFF);
		send_word(30'h15555555, 30'h2AAAAAAA);
		send_word(1000000000, 1000000000);
		send_word(999999999, 1000000000);
		send_word(1000000000, 10);
		send_word(121, 10);
		send_word(123, 10);
		send_word(12321, 10);
		send_word(1221, 10);
		send_word(30'hABBA, 16);
		send_word(255, 16);
		send_word(30'h2AAAAAAA, 3);
	endtask

	task automatic test_palindromes();
		logic [VALUE_W-1:0] number;
		logic [VALUE_W-1:0] base;
		repeat (160) begin
			number = shaped_number(1'b0, base);
			send_word(number, base);
		end
	endtask

	task automatic test_near_palindromes();
		logic [VALUE_W-1:0] number;
		logic [VALUE_W-1:0] base;
		repeat (140) begin
			number = shaped_number(1'b1, base);
			send_word(number, base);
		end
	endtask

	task automatic test_random();
		logic [VALUE_W-1:0] number;
		logic [VALUE_W-1:0] radix;
		repeat (150) begin
			number = ($urandom_range(0, 3) == 0) ? VALUE_W'($urandom_range(0, 255))
				: VALUE_W'($urandom);
			case ($urandom_range(0, 9))
				0: radix = VALUE_W'($urandom_range(0, 1));
				1, 2, 3, 4, 5: radix = VALUE_W'($urandom_range(2, 16));
				6, 7: radix = VALUE_W'($urandom_range(17, 65535));
				8: radix = VALUE_W'($urandom_range(65536, 1000000000));
				default: radix = VALUE_W'($urandom);
			endcase
			send_word(number, radix);
		end
	endtask

	initial begin : drain
		int stall;
		int drained;
		bit drain_quiet;
		drained = 0;
		drain_quiet = 1'b0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (drained % 20 == 0)
				drain_quiet = ($urandom_range(0, 3) == 0);
			stall = drain_quiet ? 0 : $urandom_range(0, 19);
			drained++;
			repeat (stall) begin
				m_tready = 1'b0;
				@(negedge clk);
			end
			m_tready = 1'b1;
			do
				@(posedge clk);
			while (!m_tvalid);
		end
	end

	always @(posedge clk) begin : check_digits
		digit_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_digits.size() == 0) begin
				$display("%0t unexpected word: expected none, actual %h last %b",
					$time, m_tdata, m_tlast);
				mismatches++;
			end else begin
				want = pending_digits.pop_front();
				if (m_tdata[VALUE_W-1:0] !== want.digit) begin
					$display("%0t digit: expected %0d, actual %0d",
						$time, want.digit, m_tdata[VALUE_W-1:0]);
					mismatches++;
				end
				if (m_tdata[VALUE_W] !== want.pal) begin
					$display("%0t is_palindrome: expected %b, actual %b",
						$time, want.pal, m_tdata[VALUE_W]);
					mismatches++;
				end
				if (m_tdata[VALUE_W+COUNT_OUT_W:VALUE_W+1] !== want.count) begin
					$display("%0t digit_count: expected %0d, actual %0d",
						$time, want.count, m_tdata[VALUE_W+COUNT_OUT_W:VALUE_W+1]);
					mismatches++;
				end
				if (m_tlast !== want.last) begin
					$display("%0t last: expected %b, actual %b", $time, want.last, m_tlast);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_palindromes();
		test_near_palindromes();
		test_random();
		s_tvalid = 1'b0;
		while (pending_digits.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
